// File: hw/rtl/pwec_pkg.sv
`default_nettype none

package pwec_pkg;

  localparam int IDX_W      = 7;
  localparam int POS_W      = 28;
  localparam int VEL_W      = 32;
  localparam int RAD_W      = 23;
  localparam int HALF_W     = 24;
  localparam int MASS_W     = 10;
  localparam int EDGE_W     = 30;
  localparam int NPOS_W     = 31;
  localparam int COEF_W     = 12;
  localparam int PROD_W     = COEF_W + VEL_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DEN_W      = MASS_W + 1;
  localparam int QUOT_W     = 34;
  localparam int SQUOT_W    = QUOT_W + 1;
  localparam int CNT_W      = $clog2(QUOT_W);
  localparam int S_TDATA_W  = 208;
  localparam int M_TDATA_W  = 128;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int PUSH_OUT = 655;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 2'd2;

  localparam logic [MASS_W-1:0] MASS_RESET = 10'd50;
  localparam logic [HALF_W-1:0] HALF_RESET = 24'd1310720;

  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_LEFT  = 2'd1;
  localparam logic [1:0] EV_RIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEOM,
    ST_FACE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_DIV1,
    ST_DIV2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VEL_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SQUOT_W-1:0] v);
    logic signed [SQUOT_W-1:0] hi;
    logic signed [SQUOT_W-1:0] lo;
    hi = SQUOT_W'(2147483647);
    lo = -hi - SQUOT_W'(1);
    if (v > hi) begin
      return {1'b0, {(VEL_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(VEL_W-1){1'b0}}};
    end
    return v[VEL_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [NPOS_W-1:0] v);
    logic signed [NPOS_W-1:0] hi;
    logic signed [NPOS_W-1:0] lo;
    hi = NPOS_W'(134217727);
    lo = -hi - NPOS_W'(1);
    if (v > hi) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end
    return v[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pwec_divider.sv
`default_nettype none

module pwec_divider
  import pwec_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire div_req_t         req_i,
  input  wire logic [DEN_W-1:0] den_i,
  output div_rsp_t              rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DEN_W-1:0]  rem_q;
  logic [QUOT_W-1:0] sh_q;
  logic              neg_q;

  logic [NUM_W-1:0]  mag;
  logic [DEN_W:0]    trial_in;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic signed [SQUOT_W-1:0] squot;

  assign mag      = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);
  assign trial_in = {rem_q, sh_q[QUOT_W-1]};
  assign ge       = trial_in >= {1'b0, den_i};
  assign trial    = trial_in - {1'b0, den_i};
  assign squot    = neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sat_vel(squot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[NUM_W-1];
      rem_q <= DEN_W'(mag[NUM_W-2:QUOT_W]);
      sh_q  <= mag[QUOT_W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? trial[DEN_W-1:0] : trial_in[DEN_W-1:0];
      sh_q  <= {sh_q[QUOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/piston_wall_elastic_collision_core.sv
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: disk and wall word, tuser: action
// m_axis    out  m_axis_tvalid/tready        tdata: result word, tuser: event
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// a load word or a word with the wall disabled goes from idle straight to the output
// state, a checked word without a hit passes the geometry and face states first, and a
// hit adds three shared multiplier passes and then two 34-step divisions in the shared divider
// reset clears the sequencer, the output valid and the wall velocity, and sets the config to its reset values
// a stalled output holds its word; the next input word is taken meanwhile, but its result waits in the output state
`default_nettype none

module piston_wall_elastic_collision_core
  import pwec_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // idx, pos, prev_pos, vel, disk_radius, wall_pos, wall_prev_pos, wall_vel_load
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // index_out, new_pos, new_prev_pos, new_vel, wall_vel
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  // event_res
  output logic [1:0]                 m_axis_tuser,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic              en_q;
  logic [MASS_W-1:0] mass_q;
  logic [HALF_W-1:0] half_q;
  logic signed [VEL_W-1:0] wall_vel_q;

  logic [IDX_W-1:0]        idx_q;
  logic signed [POS_W-1:0] pos_q, prev_q, wpos_q, wprev_q;
  logic signed [VEL_W-1:0] vel_q;
  logic [RAD_W-1:0]        rad_q;

  logic signed [POS_W-1:0] res_pos_q, res_prev_q;
  logic signed [VEL_W-1:0] res_vel_q;
  logic [1:0]              ev_q;

  logic signed [EDGE_W-1:0] ln_q, rn_q, lo_q, ro_q, re_q, le_q, pre_q, ple_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [NUM_W-1:0]  acc_q, num_q;

  logic                    out_valid_q;
  logic [M_TDATA_W-1:0]    out_data_q;
  logic [1:0]              out_ev_q;

  logic in_acc, out_load, hit;
  logic [1:0] face;
  logic signed [COEF_W-1:0] coef;
  logic signed [VEL_W-1:0]  mul_op;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [NPOS_W-1:0] new_pos;
  logic signed [EDGE_W-1:0] h_ext, r_ext;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign s_axis_tready = state_q == ST_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = state_q == ST_OUT && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ev_q;

  assign h_ext = $signed({{(EDGE_W-HALF_W){1'b0}}, half_q});
  assign r_ext = $signed({{(EDGE_W-RAD_W){1'b0}}, rad_q});

  // face selection in check order
  always_comb begin
    face = EV_NONE;
    if (re_q >= ln_q && re_q <= lo_q && wall_vel_q < 0) begin
      face = EV_LEFT;
    end else if (le_q <= rn_q && le_q >= ro_q && wall_vel_q > 0) begin
      face = EV_RIGHT;
    end else if (pre_q < ln_q && re_q >= ln_q && vel_q > 0) begin
      face = EV_LEFT;
    end else if (ple_q > rn_q && le_q <= rn_q && vel_q < 0) begin
      face = EV_RIGHT;
    end else if (re_q >= ln_q && le_q < rn_q) begin
      if (vel_q > 0) begin
        face = EV_LEFT;
      end else if (vel_q < 0) begin
        face = EV_RIGHT;
      end
    end
  end

  assign hit = (face == EV_LEFT && re_q >= ln_q && vel_q > wall_vel_q) ||
               (face == EV_RIGHT && le_q <= rn_q && vel_q < wall_vel_q);

  assign new_pos = (face == EV_LEFT)
                 ? NPOS_W'(ln_q) - NPOS_W'(r_ext) - NPOS_W'(PUSH_OUT)
                 : NPOS_W'(rn_q) + NPOS_W'(r_ext) + NPOS_W'(PUSH_OUT);

  // shared multiplier
  always_comb begin
    coef   = $signed(COEF_W'(1)) - $signed({2'b00, mass_q});
    mul_op = wall_vel_q;
    case (state_q)
      ST_MUL1: begin
        mul_op = vel_q;
      end
      ST_MUL2: begin
        coef = $signed({1'b0, mass_q, 1'b0});
      end
      default: begin
        coef = $signed({2'b00, mass_q}) - $signed(COEF_W'(1));
      end
    endcase
  end

  assign mul_p = coef * mul_op;

  always_comb begin
    div_req.start = (state_q == ST_MUL4) || (state_q == ST_DIV1 && div_rsp.done);
    div_req.num   = (state_q == ST_DIV1) ? acc_q : num_q;
  end

  pwec_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .den_i  ({1'b0, mass_q} + DEN_W'(1)),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == ACT_CHECK && en_q) begin
            state_d = ST_GEOM;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_GEOM: state_d = ST_FACE;
      ST_FACE: state_d = hit ? ST_MUL1 : ST_OUT;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_MUL4;
      ST_MUL4: state_d = ST_DIV1;
      ST_DIV1: begin
        if (div_rsp.done) begin
          state_d = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      mass_q <= MASS_RESET;
      half_q <= HALF_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE: en_q   <= cfg_data_i[0];
        CFG_MASS:   mass_q <= cfg_data_i[MASS_W-1:0];
        CFG_HALF:   half_q <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_vel_q <= '0;
    end else if (in_acc && s_axis_tuser == ACT_LOAD) begin
      wall_vel_q <= s_axis_tdata[205:174];
    end else if (state_q == ST_DIV2 && div_rsp.done) begin
      wall_vel_q <= div_rsp.quot;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_q      <= s_axis_tdata[6:0];
          pos_q      <= s_axis_tdata[34:7];
          prev_q     <= s_axis_tdata[62:35];
          vel_q      <= s_axis_tdata[94:63];
          rad_q      <= s_axis_tdata[117:95];
          wpos_q     <= s_axis_tdata[145:118];
          wprev_q    <= s_axis_tdata[173:146];
          res_pos_q  <= s_axis_tdata[34:7];
          res_prev_q <= s_axis_tdata[62:35];
          res_vel_q  <= s_axis_tdata[94:63];
          ev_q       <= EV_NONE;
        end
      end
      ST_GEOM: begin
        ln_q  <= EDGE_W'(wpos_q) - h_ext;
        rn_q  <= EDGE_W'(wpos_q) + h_ext;
        lo_q  <= EDGE_W'(wprev_q) - h_ext;
        ro_q  <= EDGE_W'(wprev_q) + h_ext;
        re_q  <= EDGE_W'(pos_q) + r_ext;
        le_q  <= EDGE_W'(pos_q) - r_ext;
        pre_q <= EDGE_W'(prev_q) + r_ext;
        ple_q <= EDGE_W'(prev_q) - r_ext;
      end
      ST_FACE: begin
        if (hit) begin
          res_prev_q <= pos_q;
          res_pos_q  <= sat_pos(new_pos);
          ev_q       <= face;
        end
      end
      ST_MUL1: begin
        prod_q <= mul_p;
      end
      ST_MUL2: begin
        acc_q  <= NUM_W'(prod_q);
        prod_q <= mul_p;
      end
      ST_MUL3: begin
        num_q  <= acc_q + NUM_W'(prod_q);
        prod_q <= mul_p;
      end
      ST_MUL4: begin
        acc_q <= NUM_W'(prod_q) + NUM_W'($signed({vel_q, 1'b0}));
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          res_vel_q <= div_rsp.quot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {1'b0, wall_vel_q, res_vel_q, res_prev_q, res_pos_q, idx_q};
      out_ev_q   <= ev_q;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pwec_checker.sv
`default_nettype none

module pwec_checker
  import pwec_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]           m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed under stall");

  // only defined event codes leave the block
  a_ev_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == EV_NONE || m_axis_tuser == EV_LEFT || m_axis_tuser == EV_RIGHT))
    else $error("undefined event code");

  // one word in the sequencer: input closes right after a word is taken
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open while a word is in flight");

endmodule

bind piston_wall_elastic_collision_core pwec_checker u_pwec_checker (.*);

`default_nettype wire
